// ----- hdl/chunky_to_planar_converter_defines.svh -----
// assertion macros for the chunky to planar converter
`ifndef CHUNKY_TO_PLANAR_CONVERTER_DEFINES_SVH
`define CHUNKY_TO_PLANAR_CONVERTER_DEFINES_SVH

// same-cycle implication, sampled on clk and disabled in reset
`define C2P_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk and disabled in reset
`define C2P_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/c2p_pkg.sv -----
// shared constants, types and line mapping for the chunky to planar converter
package c2p_pkg;

  // frame geometry
  localparam int SRC_LINES       = 224;
  localparam int GROUPS_PER_LINE = 20;
  localparam int DST_LINES       = 200;
  localparam int SHADOW_DEPTH    = SRC_LINES * GROUPS_PER_LINE;
  localparam int SLOT_W          = $clog2(SHADOW_DEPTH);

  // field widths
  localparam int LINE_W      = 8;
  localparam int GROUP_W     = 5;
  localparam int PIX_W       = 8;
  localparam int PIX_N       = 16;
  localparam int GROUP_BITS  = PIX_W * PIX_N;
  localparam int COLOR_W     = 4;
  localparam int PLANE_W     = PIX_N;
  localparam int REMAP_DEPTH = 1 << PIX_W;
  localparam int IN_DATA_W   = 160;
  localparam int OUT_DATA_W  = 80;

  // line mapping constants
  localparam int CROP_LINES = 12;
  localparam int SQUASH_NUM = 25;
  localparam int SQUASH_DEN = 28;
  // floor(n / 28) == (n * 9363) >> 18 for every n below 8192
  localparam int SQUASH_RECIP = 9363;
  localparam int SQUASH_SHIFT = 18;

  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_DROPPED = 2'd2,
    ST_REMAP   = 2'd3
  } status_t;

  typedef enum logic {
    CMD_CONVERT = 1'b0,
    CMD_REMAP   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_CROP_MODE  = 2'd0,
    CFG_X_OFFSET   = 2'd1,
    CFG_SRC_WIDTH  = 2'd2,
    CFG_SRC_HEIGHT = 2'd3
  } cfg_idx_t;

  // item held between the memory read and the result register
  typedef struct packed {
    logic                  remap;
    logic                  keep;
    logic                  use_shadow;
    logic                  last;
    logic [LINE_W-1:0]     dst_line;
    logic [GROUP_W-1:0]    dst_group;
    logic [SLOT_W-1:0]     slot;
    logic [GROUP_BITS-1:0] pix;
    logic                  byp;
    logic [GROUP_BITS-1:0] byp_data;
  } s1_t;

  // squash mapping: {keep, y * 25 / 28}, keep low when the line above maps the same
  function automatic logic [LINE_W:0] squash_map(input logic [LINE_W-1:0] y);
    logic [12:0]       n;
    logic [26:0]       prod;
    logic [LINE_W-1:0] q;
    logic [12:0]       qd;
    logic [4:0]        r;
    logic              keep;
    n    = 13'(y) * 13'(SQUASH_NUM);
    prod = 27'(n) * 27'(SQUASH_RECIP);
    q    = prod[SQUASH_SHIFT +: LINE_W];
    qd   = 13'(q) * 13'(SQUASH_DEN);
    r    = 5'(n - qd);
    // the previous line shares the quotient when the remainder is still >= 25
    keep = !((y != '0) && (r >= 5'(SQUASH_NUM)));
    return {keep, q};
  endfunction

endpackage

// ----- hdl/chunky_to_planar_converter.sv -----
// chunky to planar converter top level: remap lanes, shadow memory and result register
//
// Takes one item per clock cycle unless the result stream stalls, and gives its
// single result through the read stage register and then the result register;
// the synchronous reads of the shadow memory and of the remap table sit between
// acceptance and the result register. The remap table is kept as sixteen
// identical 256 x 4 memories, one per pixel lane, all written by each remap
// transaction, with 256 valid bits that reset clears so unwritten entries read
// as zero. The shadow copy of each source group (4480 x 128 bits) is undefined
// until that group is first written, has no clearing pass, and is written back
// when a group with status written leaves for the result register; a group read
// in that same cycle takes the written data through a bypass. tdata and tuser
// pack fields from the lowest bit up; configuration writes are always taken and
// act on transactions accepted after them.
`include "chunky_to_planar_converter_defines.svh"

module chunky_to_planar_converter (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // src_line, group_index, pixels_lo, pixels_hi, use_shadow, remap_index, remap_value
  input  logic [c2p_pkg::IN_DATA_W-1:0]    s_tdata,
  // cmd
  input  logic                             s_tuser,
  input  logic                             s_tlast,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // dst_line, dst_group, plane0, plane1, plane2, plane3
  output logic [c2p_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status
  output logic [1:0]                       m_tuser,
  output logic                             m_tlast,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [7:0]                       cfg_data
);

  // configuration registers
  logic                           crop_mode;
  logic [c2p_pkg::GROUP_W-1:0]    x_offset_groups;
  logic [c2p_pkg::GROUP_W-1:0]    src_width_groups;
  logic [c2p_pkg::LINE_W-1:0]     src_height;

  // input fields
  logic [c2p_pkg::LINE_W-1:0]     in_line;
  logic [c2p_pkg::GROUP_W-1:0]    in_group;
  logic [c2p_pkg::GROUP_BITS-1:0] in_pix;
  logic                           in_use_shadow;
  logic [c2p_pkg::PIX_W-1:0]      in_remap_index;
  logic [c2p_pkg::COLOR_W-1:0]    in_remap_value;

  // front-end decode
  logic                           in_fire;
  logic                           is_remap;
  logic [c2p_pkg::GROUP_W:0]      dst_group_sum;
  logic [c2p_pkg::LINE_W:0]       squash;
  logic                           crop_keep;
  logic                           map_keep;
  logic [c2p_pkg::LINE_W-1:0]     map_line;
  logic                           in_range;
  logic                           in_keep;
  logic [c2p_pkg::SLOT_W-1:0]     in_slot;

  // pipeline
  c2p_pkg::s1_t                   s1;
  c2p_pkg::s1_t                   s1_next;
  logic                           s1_valid;
  logic                           s1_adv;

  // remap table
  logic [c2p_pkg::REMAP_DEPTH-1:0] remap_vld;
  logic [c2p_pkg::COLOR_W-1:0]     lane_val [c2p_pkg::PIX_N];

  // shadow memory
  logic [c2p_pkg::GROUP_BITS-1:0] shadow_mem [c2p_pkg::SHADOW_DEPTH];
  logic [c2p_pkg::GROUP_BITS-1:0] shadow_rd;
  logic [c2p_pkg::GROUP_BITS-1:0] shadow_cur;
  logic                           shadow_we;

  // result
  c2p_pkg::status_t               res_status;
  logic [c2p_pkg::PLANE_W-1:0]    res_plane [4];
  c2p_pkg::status_t               out_status;
  logic [c2p_pkg::LINE_W-1:0]     out_line;
  logic [c2p_pkg::GROUP_W-1:0]    out_group;
  logic [c2p_pkg::PLANE_W-1:0]    out_plane [4];
  logic                           out_last;

  // unpack the input transaction
  assign in_line        = s_tdata[7:0];
  assign in_group       = s_tdata[12:8];
  assign in_pix         = s_tdata[140:13];
  assign in_use_shadow  = s_tdata[141];
  assign in_remap_index = s_tdata[149:142];
  assign in_remap_value = s_tdata[153:150];

  assign in_fire  = s_tvalid && s_tready;
  assign is_remap = (c2p_pkg::cmd_t'(s_tuser) == c2p_pkg::CMD_REMAP);
  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign cfg_ready = 1'b1;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      crop_mode        <= 1'b0;
      x_offset_groups  <= 5'd2;
      src_width_groups <= 5'd16;
      src_height       <= 8'd224;
    end else if (cfg_valid && cfg_ready) begin
      unique case (c2p_pkg::cfg_idx_t'(cfg_index))
        c2p_pkg::CFG_CROP_MODE:  crop_mode        <= cfg_data[0];
        c2p_pkg::CFG_X_OFFSET:   x_offset_groups  <= cfg_data[4:0];
        c2p_pkg::CFG_SRC_WIDTH:  src_width_groups <= cfg_data[4:0];
        c2p_pkg::CFG_SRC_HEIGHT: src_height       <= cfg_data;
      endcase
    end
  end

  // line mapping and range checks
  always_comb begin
    dst_group_sum = {1'b0, in_group} + {1'b0, x_offset_groups};
    squash        = c2p_pkg::squash_map(in_line);
    crop_keep     = (in_line >= 8'(c2p_pkg::CROP_LINES)) &&
                    (({1'b0, in_line} + 9'(c2p_pkg::CROP_LINES)) < 9'(c2p_pkg::SRC_LINES));
    if (crop_mode) begin
      map_keep = crop_keep;
      map_line = in_line - 8'(c2p_pkg::CROP_LINES);
    end else begin
      map_keep = squash[c2p_pkg::LINE_W];
      map_line = squash[c2p_pkg::LINE_W-1:0];
    end
    in_range = (in_group < src_width_groups) &&
               ({2'b0, in_group} < 7'(c2p_pkg::GROUPS_PER_LINE)) &&
               (in_line < src_height) &&
               ({1'b0, in_line} < 9'(c2p_pkg::SRC_LINES));
    in_keep  = in_range && map_keep &&
               ({1'b0, map_line} < 9'(c2p_pkg::DST_LINES)) &&
               ({1'b0, dst_group_sum} < 7'(c2p_pkg::GROUPS_PER_LINE));
    in_slot  = c2p_pkg::SLOT_W'(int'(in_line) * c2p_pkg::GROUPS_PER_LINE + int'(in_group));
  end

  // next contents of the read stage
  always_comb begin
    s1_next.remap      = is_remap;
    s1_next.keep       = in_keep;
    s1_next.use_shadow = in_use_shadow;
    s1_next.last       = s_tlast;
    s1_next.dst_line   = map_line;
    s1_next.dst_group  = dst_group_sum[c2p_pkg::GROUP_W-1:0];
    s1_next.slot       = in_slot;
    s1_next.pix        = in_pix;
    // a write-back in this same cycle is not yet visible in the memory read
    s1_next.byp        = shadow_we && (s1.slot == in_slot);
    s1_next.byp_data   = s1.pix;
  end

  // read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= s1_next;
    end
  end

  // remap valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      remap_vld <= '0;
    end else if (in_fire && is_remap) begin
      remap_vld[in_remap_index] <= 1'b1;
    end
  end

  // one remap table copy per pixel lane
  for (genvar i = 0; i < c2p_pkg::PIX_N; i++) begin : g_lane
    logic [c2p_pkg::COLOR_W-1:0] mem [c2p_pkg::REMAP_DEPTH];
    logic [c2p_pkg::COLOR_W-1:0] rd;
    logic                        rd_vld;
    logic [c2p_pkg::PIX_W-1:0]   idx;

    assign idx = in_pix[i*c2p_pkg::PIX_W +: c2p_pkg::PIX_W];

    always_ff @(posedge clk) begin
      if (in_fire && is_remap) begin
        mem[in_remap_index] <= in_remap_value;
      end
      if (in_fire && !is_remap) begin
        rd     <= mem[idx];
        rd_vld <= remap_vld[idx];
      end
    end

    assign lane_val[i] = rd_vld ? rd : '0;
  end

  // shadow memory: read on acceptance of a kept group, written back as a written group leaves
  always_ff @(posedge clk) begin
    if (shadow_we) begin
      shadow_mem[s1.slot] <= s1.pix;
    end
    if (in_fire && !is_remap && in_keep) begin
      shadow_rd <= shadow_mem[in_slot];
    end
  end

  // result status and bit slicing
  always_comb begin
    shadow_cur = s1.byp ? s1.byp_data : shadow_rd;
    if (s1.remap) begin
      res_status = c2p_pkg::ST_REMAP;
    end else if (!s1.keep) begin
      res_status = c2p_pkg::ST_DROPPED;
    end else if (s1.use_shadow && (shadow_cur == s1.pix)) begin
      res_status = c2p_pkg::ST_SKIPPED;
    end else begin
      res_status = c2p_pkg::ST_WRITTEN;
    end
    shadow_we = s1_valid && s1_adv && (res_status == c2p_pkg::ST_WRITTEN);
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < c2p_pkg::PIX_N; i++) begin
        res_plane[b][c2p_pkg::PIX_N-1-i] = lane_val[i][b];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_status <= res_status;
      out_last   <= s1.last;
      if ((res_status == c2p_pkg::ST_WRITTEN) || (res_status == c2p_pkg::ST_SKIPPED)) begin
        out_line  <= s1.dst_line;
        out_group <= s1.dst_group;
      end else begin
        out_line  <= '0;
        out_group <= '0;
      end
      for (int b = 0; b < 4; b++) begin
        out_plane[b] <= (res_status == c2p_pkg::ST_WRITTEN) ? res_plane[b] : '0;
      end
    end
  end

  // pack the result transaction
  assign m_tdata = {3'b000, out_plane[3], out_plane[2], out_plane[1], out_plane[0],
                    out_group, out_line};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

  // checks
  `C2P_ASSERT_SAME(a_remap_result_empty,
    m_tvalid && (m_tuser == c2p_pkg::ST_REMAP), m_tdata == '0,
    "remap result carries payload")
  `C2P_ASSERT_SAME(a_skip_no_planes,
    m_tvalid && (m_tuser == c2p_pkg::ST_SKIPPED), m_tdata[76:13] == '0,
    "skipped result carries plane data")
  `C2P_ASSERT_SAME(a_full_stalls_input,
    s1_valid && m_tvalid && !m_tready, !s_tready,
    "input taken while pipeline is full")
  `C2P_ASSERT_NEXT(a_remap_marks_valid,
    in_fire && is_remap, remap_vld[$past(in_remap_index)],
    "remap write did not set valid bit")

endmodule
